// File: hdl/svp_pkg.sv
// ----------------------------------------------------------------------------
// svp_pkg
// Shared types, widths and constants of the space vector PWM block.
// ----------------------------------------------------------------------------
package svp_pkg;

   localparam int VOLT_W  = 16;
   localparam int CMP_W   = 16;
   localparam int PER_W   = 16;
   localparam int SCALE_W = 24;
   localparam int SEC_W   = 3;
   localparam int SA_W    = 34;
   localparam int U_W     = 35;
   localparam int MAG_W   = 33;
   localparam int DWELL_W = 40;
   localparam int SUM_W   = 41;
   localparam int NUM_W   = 56;
   localparam int QUO_W   = 16;
   localparam int DIFF_W  = 33;

   localparam int DIV_STAGES  = QUO_W;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam logic signed [SA_W-1:0] SQRT3_Q16 = 34'sd113512;

   localparam int CSR_IDX_W = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE  = 8'd1;

   localparam logic [PER_W-1:0]   PERIOD_RESET = 16'd4096;
   localparam logic [SCALE_W-1:0] SCALE_RESET  = 24'd65536;

   localparam logic [SEC_W-1:0] SECTOR_ZERO = 3'd0;
   localparam logic [SEC_W-1:0] SECTOR_1    = 3'd1;
   localparam logic [SEC_W-1:0] SECTOR_2    = 3'd2;
   localparam logic [SEC_W-1:0] SECTOR_3    = 3'd3;
   localparam logic [SEC_W-1:0] SECTOR_4    = 3'd4;
   localparam logic [SEC_W-1:0] SECTOR_5    = 3'd5;
   localparam logic [SEC_W-1:0] SECTOR_6    = 3'd6;
   localparam logic [SEC_W-1:0] SECTOR_ALL  = 3'd7;

   typedef struct packed {
      logic [SEC_W-1:0] sector;
      logic [MAG_W-1:0] mag_x;
      logic [MAG_W-1:0] mag_y;
   } entry_type;

   typedef struct packed {
      logic [PER_W-1:0]   period;
      logic [SCALE_W-1:0] scale;
   } cfg_type;

   function automatic logic [MAG_W-1:0] clamp_pos(logic signed [U_W-1:0] v);
      return v[U_W-1] ? '0 : v[MAG_W-1:0];
   endfunction

   function automatic logic is_pos(logic signed [U_W-1:0] v);
      return !v[U_W-1] && (v != '0);
   endfunction

endpackage

// File: hdl/svp_front.sv
// ----------------------------------------------------------------------------
// svp_front
// Accepts voltage words, forms the three projections and the sector code,
// and pushes the selected dwell magnitudes into the queue.
// ----------------------------------------------------------------------------
module svp_front import svp_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [VOLT_W-1:0] in_alpha,
   input  logic [VOLT_W-1:0] in_beta,
   output logic              push_valid,
   input  logic              push_ready,
   output entry_type         push_entry
);

   logic                   valid_ff, valid_in;
   logic signed [SA_W-1:0] sa_ff, sa_in;
   logic [VOLT_W-1:0]      beta_ff, beta_in;

   logic signed [U_W-1:0] sa_x, b16, u1, u2, u3;
   logic [SEC_W-1:0]      sector;

   assign in_ready = !valid_ff || push_ready;

   always_comb begin
      valid_in = valid_ff;
      sa_in    = sa_ff;
      beta_in  = beta_ff;
      if (in_ready) begin
         valid_in = in_valid;
         sa_in    = SA_W'($signed(in_alpha)) * SQRT3_Q16;
         beta_in  = in_beta;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sa_ff   <= sa_in;
      beta_ff <= beta_in;
   end

   always_comb begin
      sa_x   = U_W'(sa_ff);
      b16    = $signed({{3{beta_ff[VOLT_W-1]}}, beta_ff, 16'b0});
      u1     = $signed({{2{beta_ff[VOLT_W-1]}}, beta_ff, 17'b0});
      u2     = sa_x - b16;
      u3     = -sa_x - b16;
      sector = {is_pos(u3), is_pos(u2), is_pos(u1)};
   end

   always_comb begin
      push_entry.sector = sector;
      case (sector)
         SECTOR_3: begin
            push_entry.mag_x = clamp_pos(u2);
            push_entry.mag_y = clamp_pos(u1);
         end
         SECTOR_1: begin
            push_entry.mag_x = clamp_pos(-u2);
            push_entry.mag_y = clamp_pos(-u3);
         end
         SECTOR_5: begin
            push_entry.mag_x = clamp_pos(u1);
            push_entry.mag_y = clamp_pos(u3);
         end
         SECTOR_4: begin
            push_entry.mag_x = clamp_pos(-u1);
            push_entry.mag_y = clamp_pos(-u2);
         end
         SECTOR_6: begin
            push_entry.mag_x = clamp_pos(u3);
            push_entry.mag_y = clamp_pos(u2);
         end
         SECTOR_2: begin
            push_entry.mag_x = clamp_pos(-u3);
            push_entry.mag_y = clamp_pos(-u1);
         end
         default: begin
            push_entry.mag_x = '0;
            push_entry.mag_y = '0;
         end
      endcase
   end

   assign push_valid = valid_ff;

endmodule

// File: hdl/svp_queue.sv
// ----------------------------------------------------------------------------
// svp_queue
// Short queue between the front and back parts.
// ----------------------------------------------------------------------------
module svp_queue import svp_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push_valid,
   output logic      push_ready,
   input  entry_type push_entry,
   output logic      pop_valid,
   input  logic      pop_ready,
   output entry_type pop_entry
);

   entry_type         mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;
   logic              push, pop;

   assign push_ready = (count_ff != (QPTR_W+1)'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = mem_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// File: hdl/svp_back.sv
// ----------------------------------------------------------------------------
// svp_back
// Scales the dwell times, shrinks them by a pipelined division when they
// overrun the period, and builds the centred compare values.
// ----------------------------------------------------------------------------
module svp_back import svp_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  cfg_type          cfg,
   input  logic             pop_valid,
   output logic             pop_ready,
   input  entry_type        pop_entry,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [CMP_W-1:0] rsp_cmp_a,
   output logic [CMP_W-1:0] rsp_cmp_b,
   output logic [CMP_W-1:0] rsp_cmp_c,
   output logic [SEC_W-1:0] rsp_sector,
   output logic             rsp_over
);

   typedef struct packed {
      logic [SEC_W-1:0]   sector;
      logic               over;
      logic [DWELL_W-1:0] tx;
      logic [DWELL_W-1:0] ty;
      logic [SUM_W-1:0]   sum;
      logic [NUM_W-1:0]   rem_x;
      logic [NUM_W-1:0]   rem_y;
      logic [QUO_W-1:0]   q_x;
      logic [QUO_W-1:0]   q_y;
   } dv_type;

   function automatic dv_type div_step(dv_type s, int pos);
      dv_type           r;
      logic [NUM_W:0]   d;
      r = s;
      d = (NUM_W+1)'(s.sum) << pos;
      if ({1'b0, s.rem_x} >= d) begin
         r.rem_x = s.rem_x - d[NUM_W-1:0];
         r.q_x   = s.q_x | (QUO_W'(1) << pos);
      end
      if ({1'b0, s.rem_y} >= d) begin
         r.rem_y = s.rem_y - d[NUM_W-1:0];
         r.q_y   = s.q_y | (QUO_W'(1) << pos);
      end
      return r;
   endfunction

   logic en;

   logic               b1_vld_ff, b1_vld_in;
   logic [SEC_W-1:0]   b1_sec_ff, b1_sec_in;
   logic [DWELL_W-1:0] b1_tx_ff, b1_tx_in;
   logic [DWELL_W-1:0] b1_ty_ff, b1_ty_in;
   logic [56:0]        prod_x, prod_y;

   logic               dv_vld_ff [DIV_STAGES+1];
   dv_type             dv_ff [DIV_STAGES+1];
   dv_type             dv_in [DIV_STAGES+1];
   logic [SUM_W-1:0]   sum;

   logic               e1_vld_ff, e1_vld_in;
   logic [SEC_W-1:0]   e1_sec_ff, e1_sec_in;
   logic               e1_over_ff, e1_over_in;
   logic [CMP_W-1:0]   e1_ta_ff, e1_ta_in;
   logic [CMP_W-1:0]   e1_tx_ff, e1_tx_in;
   logic [CMP_W-1:0]   e1_ty_ff, e1_ty_in;
   logic [DIFF_W-1:0]  txe, tye, diff;
   dv_type             last;

   logic               out_vld_ff, out_vld_in;
   logic [CMP_W-1:0]   out_a_ff, out_a_in;
   logic [CMP_W-1:0]   out_b_ff, out_b_in;
   logic [CMP_W-1:0]   out_c_ff, out_c_in;
   logic [SEC_W-1:0]   out_sec_ff, out_sec_in;
   logic               out_over_ff, out_over_in;
   logic [CMP_W-1:0]   ta, tb, tc;

   assign en        = !out_vld_ff || rsp_ready;
   assign pop_ready = en;

   // dwell scaling
   always_comb begin
      prod_x    = 57'(pop_entry.mag_x) * 57'(cfg.scale);
      prod_y    = 57'(pop_entry.mag_y) * 57'(cfg.scale);
      b1_vld_in = pop_valid;
      b1_sec_in = pop_entry.sector;
      b1_tx_in  = prod_x[56:17];
      b1_ty_in  = prod_y[56:17];
   end

   // overrun check and division numerators
   always_comb begin
      sum             = SUM_W'(b1_tx_ff) + SUM_W'(b1_ty_ff);
      dv_in[0].sector = b1_sec_ff;
      dv_in[0].over   = (sum > SUM_W'({cfg.period, 16'b0}));
      dv_in[0].tx     = b1_tx_ff;
      dv_in[0].ty     = b1_ty_ff;
      dv_in[0].sum    = sum;
      dv_in[0].rem_x  = NUM_W'(b1_tx_ff) * NUM_W'(cfg.period);
      dv_in[0].rem_y  = NUM_W'(b1_ty_ff) * NUM_W'(cfg.period);
      dv_in[0].q_x    = '0;
      dv_in[0].q_y    = '0;
      for (int k = 1; k <= DIV_STAGES; k++) begin
         dv_in[k] = div_step(dv_ff[k-1], DIV_STAGES - k);
      end
   end

   // zero time split
   always_comb begin
      last       = dv_ff[DIV_STAGES];
      txe        = last.over ? {1'b0, last.q_x, 16'b0} : last.tx[DIFF_W-1:0];
      tye        = last.over ? {1'b0, last.q_y, 16'b0} : last.ty[DIFF_W-1:0];
      diff       = {1'b0, cfg.period, 16'b0} - txe - tye;
      e1_vld_in  = dv_vld_ff[DIV_STAGES];
      e1_sec_in  = last.sector;
      e1_over_in = last.over;
      e1_ta_in   = CMP_W'(diff[DIFF_W-1:17]);
      e1_tx_in   = last.over ? last.q_x : last.tx[31:16];
      e1_ty_in   = last.over ? last.q_y : last.ty[31:16];
   end

   // route to phases
   always_comb begin
      ta          = e1_ta_ff;
      tb          = ta + e1_tx_ff;
      tc          = tb + e1_ty_ff;
      out_vld_in  = e1_vld_ff;
      out_sec_in  = e1_sec_ff;
      out_over_in = e1_over_ff;
      case (e1_sec_ff)
         SECTOR_3: begin
            out_a_in = ta; out_b_in = tb; out_c_in = tc;
         end
         SECTOR_1: begin
            out_a_in = tb; out_b_in = ta; out_c_in = tc;
         end
         SECTOR_5: begin
            out_a_in = tc; out_b_in = ta; out_c_in = tb;
         end
         SECTOR_4: begin
            out_a_in = tc; out_b_in = tb; out_c_in = ta;
         end
         SECTOR_6: begin
            out_a_in = tb; out_b_in = tc; out_c_in = ta;
         end
         SECTOR_2: begin
            out_a_in = ta; out_b_in = tc; out_c_in = tb;
         end
         default: begin
            out_a_in    = cfg.period;
            out_b_in    = cfg.period;
            out_c_in    = cfg.period;
            out_over_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_vld_ff  <= 1'b0;
         e1_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         for (int k = 0; k <= DIV_STAGES; k++) begin
            dv_vld_ff[k] <= 1'b0;
         end
      end else if (en) begin
         b1_vld_ff    <= b1_vld_in;
         dv_vld_ff[0] <= b1_vld_ff;
         for (int k = 1; k <= DIV_STAGES; k++) begin
            dv_vld_ff[k] <= dv_vld_ff[k-1];
         end
         e1_vld_ff  <= e1_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b1_sec_ff <= b1_sec_in;
         b1_tx_ff  <= b1_tx_in;
         b1_ty_ff  <= b1_ty_in;
         for (int k = 0; k <= DIV_STAGES; k++) begin
            dv_ff[k] <= dv_in[k];
         end
         e1_sec_ff   <= e1_sec_in;
         e1_over_ff  <= e1_over_in;
         e1_ta_ff    <= e1_ta_in;
         e1_tx_ff    <= e1_tx_in;
         e1_ty_ff    <= e1_ty_in;
         out_a_ff    <= out_a_in;
         out_b_ff    <= out_b_in;
         out_c_ff    <= out_c_in;
         out_sec_ff  <= out_sec_in;
         out_over_ff <= out_over_in;
      end
   end

   assign rsp_valid  = out_vld_ff;
   assign rsp_cmp_a  = out_a_ff;
   assign rsp_cmp_b  = out_b_ff;
   assign rsp_cmp_c  = out_c_ff;
   assign rsp_sector = out_sec_ff;
   assign rsp_over   = out_over_ff;

endmodule

// File: hdl/space_vector_pwm.sv
// The 16-stage restoring divider between b1 and e1 is fully pipelined.
// Throughput: one vector per cycle while the output is not stalled.
// A four-word queue between front and back absorbs short output stalls.
// Reset (synchronous, active high) empties the pipeline and queue and loads
// pwm_period = 4096 and dwell_scale = 65536.
// ----------------------------------------------------------------------------
// space_vector_pwm
// Three-phase space vector PWM compare generator with configuration port.
// ----------------------------------------------------------------------------
module space_vector_pwm import svp_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [31:0]          req_tdata,   // volt_alpha, volt_beta
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [47:0]          rsp_tdata,   // compare_a, compare_b, compare_c
   output logic [3:0]           rsp_tuser,   // sector_code, overmodulated
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [SCALE_W-1:0]   csr_data
);

   logic [PER_W-1:0]   period_ff, period_in;
   logic [SCALE_W-1:0] scale_ff, scale_in;
   cfg_type            cfg;

   logic      push_valid, push_ready, pop_valid, pop_ready;
   entry_type push_entry, pop_entry;

   logic [CMP_W-1:0] cmp_a, cmp_b, cmp_c;
   logic [SEC_W-1:0] sector;
   logic             over;

   assign csr_ready = 1'b1;

   always_comb begin
      period_in = period_ff;
      scale_in  = scale_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_PERIOD: period_in = csr_data[PER_W-1:0];
            CSR_SCALE:  scale_in  = csr_data;
            default:    ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= PERIOD_RESET;
         scale_ff  <= SCALE_RESET;
      end else begin
         period_ff <= period_in;
         scale_ff  <= scale_in;
      end
   end

   assign cfg.period = period_ff;
   assign cfg.scale  = scale_ff;

   svp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_alpha   (req_tdata[15:0]),
      .in_beta    (req_tdata[31:16]),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   svp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   svp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_cmp_a  (cmp_a),
      .rsp_cmp_b  (cmp_b),
      .rsp_cmp_c  (cmp_c),
      .rsp_sector (sector),
      .rsp_over   (over)
   );

   assign rsp_tdata = {cmp_c, cmp_b, cmp_a};
   assign rsp_tuser = {over, sector};

endmodule

// File: tb/svp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svp_checker
// Passive checker for space_vector_pwm. It tracks register writes, works out
// the compare word for each accepted voltage vector and compares results in
// order. It reports leftover expectations once the stream is closed.
// ----------------------------------------------------------------------------
module svp_checker import svp_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic                 req_tready,
   input  logic [31:0]          req_tdata,   // volt_alpha, volt_beta
   input  logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  logic [47:0]          rsp_tdata,   // compare_a, compare_b, compare_c
   input  logic [3:0]           rsp_tuser,   // sector_code, overmodulated
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [SCALE_W-1:0]   csr_data,
   input  logic                 stream_closed,
   output int                   fail_count,
   output int                   pending
);

   typedef logic [63:0] wide_type;

   typedef struct packed {
      logic [CMP_W-1:0] cmp_c;
      logic [CMP_W-1:0] cmp_b;
      logic [CMP_W-1:0] cmp_a;
      logic             over;
      logic [SEC_W-1:0] sector;
   } compare_word_type;

   compare_word_type   compare_q[$];
   logic [PER_W-1:0]   period_cfg = PERIOD_RESET;
   logic [SCALE_W-1:0] scale_cfg  = SCALE_RESET;
   int                 mismatches = 0;
   int                 queued     = 0;
   bit                 leftovers_counted = 1'b0;

   assign fail_count = mismatches;
   assign pending    = queued;

   function automatic wide_type dwell_counts(longint twice_u, logic [SCALE_W-1:0] scale);
      if (twice_u <= 0) return '0;
      return (wide_type'(twice_u) * scale) >> 17;
   endfunction

   function automatic compare_word_type predict_compares(logic [31:0] vec,
                                                         logic [PER_W-1:0] per,
                                                         logic [SCALE_W-1:0] scale);
      longint           alpha, beta, sa, b16, u1, u2, u3;
      wide_type         tx, ty, sum, full, nx, ny, ta, tb, tc;
      compare_word_type w;
      alpha = longint'($signed(vec[15:0]));
      beta  = longint'($signed(vec[31:16]));
      sa    = alpha * longint'(SQRT3_Q16);
      b16   = beta * 65536;
      u1    = b16 * 2;
      u2    = sa - b16;
      u3    = -sa - b16;
      w     = '0;
      w.sector = {u3 > 0, u2 > 0, u1 > 0};
      tx = '0;
      ty = '0;
      case (w.sector)
         SECTOR_3: begin tx = dwell_counts(u2, scale);  ty = dwell_counts(u1, scale);  end
         SECTOR_1: begin tx = dwell_counts(-u2, scale); ty = dwell_counts(-u3, scale); end
         SECTOR_5: begin tx = dwell_counts(u1, scale);  ty = dwell_counts(u3, scale);  end
         SECTOR_4: begin tx = dwell_counts(-u1, scale); ty = dwell_counts(-u2, scale); end
         SECTOR_6: begin tx = dwell_counts(u3, scale);  ty = dwell_counts(u2, scale);  end
         SECTOR_2: begin tx = dwell_counts(-u3, scale); ty = dwell_counts(-u1, scale); end
         default: ;
      endcase
      if (w.sector == SECTOR_ZERO || w.sector == SECTOR_ALL) begin
         w.cmp_a = per;
         w.cmp_b = per;
         w.cmp_c = per;
         return w;
      end
      full = wide_type'(per) << 16;
      sum  = tx + ty;
      if (sum > full) begin
         nx = (tx * per) / sum;
         ny = (ty * per) / sum;
         tx = nx << 16;
         ty = ny << 16;
         w.over = 1'b1;
      end
      ta = (full - tx - ty) >> 17;
      tb = ta + (tx >> 16);
      tc = tb + (ty >> 16);
      case (w.sector)
         SECTOR_3: {w.cmp_a, w.cmp_b, w.cmp_c} = {ta[15:0], tb[15:0], tc[15:0]};
         SECTOR_1: {w.cmp_a, w.cmp_b, w.cmp_c} = {tb[15:0], ta[15:0], tc[15:0]};
         SECTOR_5: {w.cmp_a, w.cmp_b, w.cmp_c} = {tc[15:0], ta[15:0], tb[15:0]};
         SECTOR_4: {w.cmp_a, w.cmp_b, w.cmp_c} = {tc[15:0], tb[15:0], ta[15:0]};
         SECTOR_6: {w.cmp_a, w.cmp_b, w.cmp_c} = {tb[15:0], tc[15:0], ta[15:0]};
         default:  {w.cmp_a, w.cmp_b, w.cmp_c} = {ta[15:0], tc[15:0], tb[15:0]};
      endcase
      return w;
   endfunction

   task automatic report(input string what, input compare_word_type want,
                         input compare_word_type got);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t %s: expected a=%0d b=%0d c=%0d sec=%0d ovm=%0b, %s",
                  $realtime, what, want.cmp_a, want.cmp_b, want.cmp_c, want.sector,
                  want.over,
                  $sformatf("got a=%0d b=%0d c=%0d sec=%0d ovm=%0b",
                            got.cmp_a, got.cmp_b, got.cmp_c, got.sector, got.over));
   endtask

   always @(posedge clock) begin
      compare_word_type got;
      compare_word_type want;
      if (reset) begin
         period_cfg <= PERIOD_RESET;
         scale_cfg  <= SCALE_RESET;
         compare_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_PERIOD) period_cfg <= csr_data[PER_W-1:0];
            else if (csr_index == CSR_SCALE) scale_cfg <= csr_data;
         end
         if (req_tvalid && req_tready)
            compare_q.push_back(predict_compares(req_tdata, period_cfg, scale_cfg));
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata, rsp_tuser[3], rsp_tuser[2:0]};
            if (compare_q.size() == 0) begin
               report("unexpected word", '0, got);
            end else begin
               want = compare_q.pop_front();
               if (got !== want) report("mismatch", want, got);
            end
         end
         if (stream_closed && !leftovers_counted) begin
            leftovers_counted = 1'b1;
            while (compare_q.size() != 0) begin
               want = compare_q.pop_front();
               report("missing word", want, '0);
            end
         end
      end
      queued = compare_q.size();
   end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for space_vector_pwm. Drives corner vectors, then
// random vectors under a series of period and scale settings, with random
// gaps on both streams, a gap-free stretch and one long output stall.
// Checking is done by svp_checker.
// ----------------------------------------------------------------------------
module tb_top;
   import svp_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int HOLD_LEN       = 400;
   localparam int DRAIN_CYCLES   = 40;
   localparam int PHASES         = 8;
   localparam int PHASE_ITEMS    = 216;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_LO = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_HI = 8'hFF;

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic [31:0]          req_tdata  = '0;
   logic                 rsp_tready = 1'b0;
   logic                 csr_valid  = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index  = '0;
   logic [SCALE_W-1:0]   csr_data   = '0;
   logic                 req_tready;
   logic                 rsp_tvalid;
   logic [47:0]          rsp_tdata;
   logic [3:0]           rsp_tuser;
   logic                 csr_ready;

   bit calm          = 1'b0;
   bit hold_req      = 1'b0;
   bit stream_closed = 1'b0;
   int hold_cycles   = 0;
   int idle_cycles   = 0;
   int fail_count;
   int pending;

   // {volt_beta, volt_alpha}
   logic [31:0] corner_vectors [22] = '{
      {16'h0000, 16'h0000}, {16'h0000, 16'h7FFF}, {16'h0000, 16'h8000},
      {16'h7FFF, 16'h0000}, {16'h8000, 16'h0000}, {16'h7FFF, 16'h7FFF},
      {16'h8000, 16'h8000}, {16'h8000, 16'h7FFF}, {16'h7FFF, 16'h8000},
      {16'h0000, 16'h0001}, {16'h0001, 16'h0000}, {16'h0000, 16'hFFFF},
      {16'hFFFF, 16'h0000}, {16'h0064, 16'h00C8}, {16'h00C8, 16'h0000},
      {16'h0064, 16'hFF38}, {16'hFF9C, 16'hFF38}, {16'hFF38, 16'h0000},
      {16'hFF9C, 16'h00C8}, {16'h0100, 16'h0100}, {16'h5555, 16'hAAAA},
      {16'hAAAA, 16'h5555}
   };

   logic [PER_W-1:0]   period_plan [4] = '{16'hFFFF, 16'd1, 16'hFFFF, 16'd0};
   logic [SCALE_W-1:0] scale_plan  [4] = '{24'hFFFFFF, 24'hFFFFFF, 24'd0, 24'd65536};

   space_vector_pwm dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   svp_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .stream_closed (stream_closed),
      .fail_count    (fail_count),
      .pending       (pending)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // hold off once for a long stretch, keep ready high while calm, otherwise drop ready at random
   always @(posedge clock) begin
      if (hold_req && hold_cycles < HOLD_LEN) begin
         rsp_tready  <= 1'b0;
         hold_cycles <= hold_cycles + 1;
      end else if (calm) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= 12);
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("[space_vector_pwm] ERROR");
         $finish;
      end
   end

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [SCALE_W-1:0] value);
      csr_index <= idx;
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_vector(input logic [15:0] alpha, input logic [15:0] beta);
      if (!calm && $urandom_range(99) < 12) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < 12);
      end
      req_tdata  <= {beta, alpha};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
   endtask

   // drop valid, wait for every expected word, then let the pipeline empty
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic run_random(input int count);
      logic [31:0] r;
      logic [15:0] alpha;
      logic [15:0] beta;
      logic [15:0] picks [5];
      picks = '{16'h8000, 16'h7FFF, 16'h0000, 16'h0001, 16'hFFFF};
      for (int i = 0; i < count; i++) begin
         r = $urandom;
         case ($urandom_range(9))
            0, 1, 2, 3: begin
               alpha = r[15:0];
               beta  = r[31:16];
            end
            4, 5, 6: begin
               alpha = {{5{r[10]}}, r[10:0]};
               beta  = {{5{r[26]}}, r[26:16]};
            end
            7: begin
               alpha = r[0] ? r[31:16] : 16'h0000;
               beta  = r[0] ? 16'h0000 : r[31:16];
            end
            8: begin
               alpha = r[15:0];
               beta  = r[16] ? r[15:0] : -r[15:0];
            end
            default: begin
               alpha = picks[$urandom_range(4)];
               beta  = picks[$urandom_range(4)];
            end
         endcase
         send_vector(alpha, beta);
      end
   endtask

   initial begin
      logic [PER_W-1:0]   period;
      logic [SCALE_W-1:0] scale;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (corner_vectors[i]) send_vector(corner_vectors[i][15:0], corner_vectors[i][31:16]);
      settle();

      for (int p = 0; p < PHASES; p++) begin
         if (p < 4) begin
            period = period_plan[p];
            scale  = scale_plan[p];
         end else begin
            period = 16'($urandom_range(65535, 1));
            scale  = 24'($urandom) >> $urandom_range(16);
         end
         write_reg(CSR_PERIOD, {8'($urandom), period});
         write_reg(CSR_SCALE, scale);
         if (p == 2 || p == 5) begin
            write_reg(CSR_UNUSED_LO, 24'($urandom));
            write_reg(CSR_UNUSED_HI, 24'hFFFFFF);
         end
         calm     <= (p == 5);
         hold_req <= hold_req || (p == 6);
         run_random(PHASE_ITEMS);
         settle();
      end

      stream_closed <= 1'b1;
      repeat (2) @(posedge clock);
      if (fail_count == 0)
         $display("[space_vector_pwm] OK");
      else
         $display("[space_vector_pwm] ERROR");
      $finish;
   end

endmodule

// File: space_vector_pwm.f
hdl/svp_pkg.sv
hdl/svp_front.sv
hdl/svp_queue.sv
hdl/svp_back.sv
hdl/space_vector_pwm.sv
tb/svp_checker.sv
tb/tb_top.sv
